>>> hw/rtl/multi_standard_crc_engine_unit_defines.svh
// assertion macros for the multi-standard crc engine
// included by the rtl modules that carry concurrent checks; no other dependencies
`ifndef MULTI_STANDARD_CRC_ENGINE_UNIT_DEFINES_SVH
`define MULTI_STANDARD_CRC_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication, checks off while in reset
`define MSCRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checks off while in reset
`define MSCRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/mscrc_pkg.sv
// shared types, constants and crc update functions for the crc engine
// no dependencies; imported by every rtl module of the block
`default_nettype none

package mscrc_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [1:0]  VARIANT_RST = 2'd2;
  localparam logic [7:0]  POLY8       = 8'h07;
  localparam logic [15:0] POLY16      = 16'h1021;
  localparam logic [31:0] POLY32_REFL = 32'hEDB88320;
  localparam logic [7:0]  INIT8       = 8'h00;
  localparam logic [15:0] INIT16      = 16'hFFFF;
  localparam logic [31:0] INIT32      = 32'hFFFFFFFF;
  localparam logic [31:0] XOROUT32    = 32'hFFFFFFFF;

  typedef enum logic [2:0] {
    KIND_CRC8  = 3'b001,
    KIND_CRC16 = 3'b010,
    KIND_CRC32 = 3'b100
  } crc_kind_t;

  typedef struct packed {
    crc_kind_t  kind;
    logic [7:0] data;
    logic       last;
  } mscrc_item_t;

  typedef struct packed {
    logic        valid;
    mscrc_item_t item;
  } mscrc_xfer_t;

  function automatic logic [7:0] upd8(input logic [7:0] c_in, input logic [7:0] b);
    logic [7:0] c;
    c = c_in ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ POLY8) : (c << 1);
    end
    return c;
  endfunction

  function automatic logic [15:0] upd16(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ POLY16) : (c << 1);
    end
    return c;
  endfunction

  function automatic logic [31:0] upd32(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'h000000, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ POLY32_REFL) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mscrc_front.sv
// front end: holds the variant register, accepts input words and tags them
// with the decoded crc kind; depends on mscrc_pkg
`default_nettype none

module mscrc_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  cfg_wr_en,
  input  wire  [1:0]           cfg_wr_data,
  input  wire                  in_tvalid,
  output logic                 in_tready,
  input  wire  [7:0]           in_tdata,
  input  wire                  in_tlast,
  output mscrc_pkg::mscrc_xfer_t push,
  input  wire                  push_ready
);
  import mscrc_pkg::*;

  logic [1:0] variant_r;
  logic [1:0] variant_nxt;
  crc_kind_t  kind;

  always_comb begin
    variant_nxt = cfg_wr_en ? cfg_wr_data : variant_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      variant_r <= VARIANT_RST;
    end else begin
      variant_r <= variant_nxt;
    end
  end

  // bit 1 wins, so code three runs as crc-32
  always_comb begin
    if (variant_r[1]) begin
      kind = KIND_CRC32;
    end else if (variant_r[0]) begin
      kind = KIND_CRC16;
    end else begin
      kind = KIND_CRC8;
    end
  end

  assign in_tready       = push_ready;
  assign push.valid      = in_tvalid;
  assign push.item.kind  = kind;
  assign push.item.data  = in_tdata;
  assign push.item.last  = in_tlast;

endmodule

`default_nettype wire

>>> hw/rtl/mscrc_queue.sv
// short fifo between front and back end, registers only
// depends on mscrc_pkg and the assertion macro header
`default_nettype none

module mscrc_queue #(
  parameter int unsigned DEPTH = mscrc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  mscrc_pkg::mscrc_xfer_t push,
  output logic                   push_ready,
  output mscrc_pkg::mscrc_xfer_t head,
  input  wire                    pop
);
  import mscrc_pkg::*;
  `include "multi_standard_crc_engine_unit_defines.svh"

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  mscrc_item_t      slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != CNT_FULL);
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop && (count_r != '0);

  assign head.valid = (count_r != '0);
  assign head.item  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push.item;
    end
  end

  `MSCRC_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, count_r <= CNT_FULL, "queue count over depth")
  `MSCRC_ASSERT_NXT(a_cnt_up, clk, rst_n, do_push && !do_pop, count_r == $past(count_r) + 1'b1, "queue count did not grow on push")
  `MSCRC_ASSERT_NXT(a_cnt_dn, clk, rst_n, do_pop && !do_push, count_r == $past(count_r) - 1'b1, "queue count did not shrink on pop")

endmodule

`default_nettype wire

>>> hw/rtl/mscrc_back.sv
// back end: keeps the running crc, updates it one byte a cycle unless the output
// stalls, and holds the finalized result in an output register; uses mscrc_pkg, macros
`default_nettype none

module mscrc_back (
  input  wire                    clk,
  input  wire                    rst_n,
  input  mscrc_pkg::mscrc_xfer_t head,
  output logic                   pop,
  output logic                   out_tvalid,
  input  wire                    out_tready,
  output logic [31:0]            out_tdata,
  output logic                   out_tlast
);
  import mscrc_pkg::*;
  `include "multi_standard_crc_engine_unit_defines.svh"

  logic [31:0] crc_r, crc_nxt;
  logic        start_r, start_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_crc_r, out_crc_nxt;
  logic        out_last_r, out_last_nxt;
  logic [31:0] crc_new;
  logic [31:0] crc_fin;

  // output slot is free or being drained this cycle
  assign pop = head.valid && (!out_valid_r || out_tready);

  always_comb begin
    case (head.item.kind)
      KIND_CRC8: begin
        crc_new = {24'h000000, upd8(start_r ? INIT8 : crc_r[7:0], head.item.data)};
        crc_fin = crc_new;
      end
      KIND_CRC16: begin
        crc_new = {16'h0000, upd16(start_r ? INIT16 : crc_r[15:0], head.item.data)};
        crc_fin = crc_new;
      end
      default: begin
        crc_new = upd32(start_r ? INIT32 : crc_r, head.item.data);
        crc_fin = crc_new ^ XOROUT32;
      end
    endcase
  end

  always_comb begin
    crc_nxt       = crc_r;
    start_nxt     = start_r;
    out_valid_nxt = out_valid_r;
    out_crc_nxt   = out_crc_r;
    out_last_nxt  = out_last_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (pop) begin
      crc_nxt       = crc_new;
      start_nxt     = head.item.last;
      out_valid_nxt = 1'b1;
      out_crc_nxt   = crc_fin;
      out_last_nxt  = head.item.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= '0;
      start_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      crc_r       <= crc_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_crc_r  <= out_crc_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_crc_r;
  assign out_tlast  = out_last_r;

  `MSCRC_ASSERT_NXT(a_pop_fills, clk, rst_n, pop, out_valid_r, "output slot empty after pop")
  `MSCRC_ASSERT_NXT(a_start_tracks_last, clk, rst_n, pop, start_r == $past(head.item.last), "message start flag does not follow last")
  `MSCRC_ASSERT_NXT(a_crc8_width, clk, rst_n, pop && (head.item.kind == KIND_CRC8), crc_r[31:8] == 24'h000000, "crc-8 state wider than 8 bits")
  `MSCRC_ASSERT_IMP(a_no_pop_blocked, clk, rst_n, out_valid_r && !out_tready, !pop, "pop while output slot stalled")

endmodule

`default_nettype wire

>>> hw/rtl/multi_standard_crc_engine_unit.sv
// path: an accepted word is written into a queue slot, then loaded into the output
// register, from which it leaves on the output stream
// throughput: one word per cycle while out_tready holds; the crc update loop in the
// back end is combinational, and the queue absorbs output stalls up to its depth
// reset: synchronous active-low rst_n clears the queue and output slot, sets the
// running crc to zero, arms the message-start flag and selects crc-32
`default_nettype none

module multi_standard_crc_engine_unit #(
  parameter int unsigned QUEUE_DEPTH = mscrc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_wr_en,
  input  wire  [1:0]  cfg_wr_data,  // crc_variant
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,     // data_byte
  input  wire         in_tlast,     // last_byte
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata,    // crc_value
  output logic        out_tlast     // message_done
);
  import mscrc_pkg::*;

  mscrc_xfer_t push;
  mscrc_xfer_t head;
  logic        push_ready;
  logic        pop;

  mscrc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .push       (push),
    .push_ready (push_ready)
  );

  mscrc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_ready(push_ready),
    .head      (head),
    .pop       (pop)
  );

  mscrc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule

`default_nettype wire

>>> verif/multi_standard_crc_engine_unit_test.sv
// self-checking bench for multi_standard_crc_engine_unit: byte messages under all crc variants,
// random idle on both stream sides, every result word checked against an in-bench crc model
// depends on mscrc_pkg and the crc engine rtl only
`timescale 1ns / 100ps

module multi_standard_crc_engine_unit_test;
  import mscrc_pkg::*;

  localparam logic [1:0] VAR_CRC8      = 2'd0;
  localparam logic [1:0] VAR_CRC16     = 2'd1;
  localparam logic [1:0] VAR_CRC32     = 2'd2;
  localparam logic [1:0] VAR_CRC32_ALT = 2'd3;

  localparam int unsigned BYTE_TARGET = 800;
  localparam int unsigned QUIET_WAIT  = 4;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef enum logic [1:0] {
    PLAN_BYTE,
    PLAN_SET_VARIANT,
    PLAN_DRAIN
  } plan_kind_e;

  typedef struct {
    plan_kind_e kind;
    logic [7:0] data;
    logic       last;
    logic [1:0] variant;
  } plan_entry_t;

  typedef struct {
    logic [31:0] crc;
    logic        done;
  } crc_result_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [1:0]  cfg_wr_data = 2'd0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = 8'd0;  // data_byte
  logic        in_tlast    = 1'b0;  // last_byte
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [31:0] out_tdata;           // crc_value
  logic        out_tlast;           // message_done

  plan_entry_t message_plan[$];
  crc_result_t crc_expected[$];

  // model state of the engine
  logic [1:0]  variant_sel = VAR_CRC32;
  logic [31:0] crc_state   = 32'd0;
  logic        msg_start   = 1'b1;

  logic        in_taken    = 1'b0;
  logic        calm        = 1'b0;
  int unsigned gap_left    = 0;
  int unsigned stall_left  = 0;
  int unsigned quiet_cnt   = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatches  = 0;

  multi_standard_crc_engine_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  always #1 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // bit-serial crc updates, data bit by data bit
  function automatic logic [7:0] crc8_byte(input logic [7:0] c, input logic [7:0] d);
    logic fb;
    for (int k = 7; k >= 0; k--) begin
      fb = c[7] ^ d[k];
      c  = {c[6:0], 1'b0} ^ (fb ? POLY8 : 8'h00);
    end
    return c;
  endfunction

  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] d);
    logic fb;
    for (int k = 7; k >= 0; k--) begin
      fb = c[15] ^ d[k];
      c  = {c[14:0], 1'b0} ^ (fb ? POLY16 : 16'h0000);
    end
    return c;
  endfunction

  function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] d);
    logic fb;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ d[k];
      c  = {1'b0, c[31:1]} ^ (fb ? POLY32_REFL : 32'h0);
    end
    return c;
  endfunction

  // advance the model by one accepted word and queue the crc it must produce
  task automatic advance_crc(input logic [7:0] d, input logic last);
    crc_result_t r;
    logic [31:0] c;
    if (variant_sel == VAR_CRC32 || variant_sel == VAR_CRC32_ALT) begin
      c     = crc32_byte(msg_start ? INIT32 : crc_state, d);
      r.crc = c ^ XOROUT32;
    end else if (variant_sel == VAR_CRC16) begin
      c     = {16'h0, crc16_byte(msg_start ? INIT16 : crc_state[15:0], d)};
      r.crc = c;
    end else begin
      c     = {24'h0, crc8_byte(msg_start ? INIT8 : crc_state[7:0], d)};
      r.crc = c;
    end
    r.done    = last;
    crc_state = c;
    msg_start = last;
    crc_expected.push_back(r);
  endtask

  task automatic add_byte(input logic [7:0] d, input logic last);
    message_plan.push_back('{PLAN_BYTE, d, last, 2'd0});
  endtask

  task automatic add_variant(input logic [1:0] v);
    message_plan.push_back('{PLAN_SET_VARIANT, 8'd0, 1'b0, v});
  endtask

  task automatic add_drain();
    message_plan.push_back('{PLAN_DRAIN, 8'd0, 1'b0, 2'd0});
  endtask

  // input side driver
  always @(negedge clk) begin : drive_in
    logic       nxt_valid;
    logic [7:0] nxt_data;
    logic       nxt_last;
    logic       nxt_wr;
    logic [1:0] nxt_cfg;
    nxt_valid = in_tvalid;
    nxt_data  = in_tdata;
    nxt_last  = in_tlast;
    nxt_wr    = 1'b0;
    nxt_cfg   = cfg_wr_data;
    if (rst_n) begin
      if (in_tvalid && in_taken) nxt_valid = 1'b0;
      if (!nxt_valid) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (message_plan.size() != 0) begin
          if (message_plan[0].kind == PLAN_BYTE) begin
            nxt_valid = 1'b1;
            nxt_data  = message_plan[0].data;
            nxt_last  = message_plan[0].last;
            void'(message_plan.pop_front());
            gap_left  = pick_gap();
          end else if (crc_expected.size() == 0) begin
            // register writes and pauses wait for the pipe to run dry
            if (quiet_cnt < QUIET_WAIT) begin
              quiet_cnt++;
            end else begin
              if (message_plan[0].kind == PLAN_SET_VARIANT) begin
                nxt_wr  = 1'b1;
                nxt_cfg = message_plan[0].variant;
              end
              void'(message_plan.pop_front());
              quiet_cnt = 0;
            end
          end
        end
      end
    end
    in_tvalid   <= nxt_valid;
    in_tdata    <= nxt_data;
    in_tlast    <= nxt_last;
    cfg_wr_en   <= nxt_wr;
    cfg_wr_data <= nxt_cfg;
  end

  // output side backpressure
  always @(negedge clk) begin : drive_out
    logic nxt_ready;
    nxt_ready = 1'b1;
    if (stall_left != 0) begin
      stall_left--;
      nxt_ready = 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = pick_gap();
      nxt_ready  = (stall_left == 0);
    end
    out_tready <= nxt_ready;
  end

  // monitor and checker
  always @(posedge clk) begin : watch
    crc_result_t want;
    in_taken <= in_tvalid && in_tready;
    if (rst_n) begin
      if (cycle_count % 256 == 0) calm = ($urandom_range(0, 3) == 0);
      if (cfg_wr_en) variant_sel = cfg_wr_data;
      if (in_tvalid && in_tready) advance_crc(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (crc_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("crc word with nothing expected: crc=%h done=%b", out_tdata, out_tlast);
        end else begin
          want = crc_expected.pop_front();
          if (out_tdata !== want.crc || out_tlast !== want.done) begin
            mismatches++;
            if (mismatches <= 10)
              $display("crc mismatch: expected crc=%h done=%b, got crc=%h done=%b",
                       want.crc, want.done, out_tdata, out_tlast);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("multi_standard_crc_engine_unit_test: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned n_bytes;
    int unsigned phase;
    int unsigned len;

    // reset variant is crc-32
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b1);
    add_byte(8'h80, 1'b0);
    add_byte(8'h01, 1'b1);
    add_variant(VAR_CRC8);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h80, 1'b1);
    add_variant(VAR_CRC16);
    add_byte(8'h00, 1'b1);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h01, 1'b1);
    // code three decodes as crc-32
    add_variant(VAR_CRC32_ALT);
    add_byte(8'hA5, 1'b0);
    add_byte(8'h5A, 1'b1);
    // switching variant inside a message keeps the running value, cut to width
    add_variant(VAR_CRC16);
    add_byte(8'h12, 1'b0);
    add_byte(8'h34, 1'b0);
    add_variant(VAR_CRC8);
    add_byte(8'h56, 1'b0);
    add_variant(VAR_CRC32);
    add_byte(8'h78, 1'b0);
    add_variant(VAR_CRC16);
    add_byte(8'h9A, 1'b1);
    add_drain();

    n_bytes = 0;
    phase   = 0;
    while (n_bytes < BYTE_TARGET) begin
      add_variant(phase < 4 ? 2'(phase) : 2'($urandom_range(0, 3)));
      repeat ($urandom_range(2, 8)) begin
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
          if (i > 0 && $urandom_range(0, 40) == 0) add_variant(2'($urandom_range(0, 3)));
          add_byte(8'($urandom_range(0, 255)), i == len - 1);
          n_bytes++;
        end
      end
      if (phase % 3 == 2) add_drain();
      phase++;
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (message_plan.size() == 0 && !in_tvalid && crc_expected.size() == 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && crc_expected.size() == 0) begin
      $display("multi_standard_crc_engine_unit_test: done, clean");
    end else begin
      $display("multi_standard_crc_engine_unit_test: done, errors");
    end
    $finish;
  end

endmodule
